// ===== hw/rtl/held_karp_open_path_solver_defines.svh =====
// Assertion helpers used by the solver's controller.
`ifndef HELD_KARP_OPEN_PATH_SOLVER_DEFINES_SVH
`define HELD_KARP_OPEN_PATH_SOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKOPS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hkops same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HKOPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hkops next-cycle check failed");

`endif

// ===== hw/rtl/hkops_pkg.sv =====
`default_nettype none
package hkops_pkg;

    localparam int COST_W = 24;
    localparam int ARC_W  = 16;

    localparam logic [COST_W-1:0] INF_COST = 24'hFFFFFF;
    localparam logic [ARC_W-1:0]  ARC_NONE = 16'hFFFF;

    // Configuration register indexes.
    localparam int REG_NODE_COUNT = 0;
    localparam int REG_START_NODE = 1;

    // Input commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CLEAR,
        ST_SEED,
        ST_MASK,
        ST_JCHK,
        ST_JWAIT,
        ST_KCHK,
        ST_KWAIT,
        ST_BEST,
        ST_BWAIT,
        ST_BDONE,
        ST_TRACE,
        ST_TWAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_CUR,
        RD_RELAX,
        RD_BEST,
        RD_TRACE
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_SEED,
        WR_RELAX
    } wr_sel_t;

    typedef struct packed {
        logic    load_arc;
        logic    start;
        logic    clr_step;
        logic    mask_reset;
        logic    mask_inc;
        logic    j_reset;
        logic    j_inc;
        logic    k_reset;
        logic    k_inc;
        logic    latch_cur;
        logic    best_init;
        logic    best_cmp;
        logic    trace_init;
        logic    trace_step;
        logic    emit_single;
        logic    emit_fail;
        logic    emit_ok;
        logic    pos_inc;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } cmd_t;

    typedef struct packed {
        logic n_is_one;
        logic clr_done;
        logic mask_done;
        logic mask_has_depot;
        logic j_done;
        logic j_in_mask;
        logic cur_inf;
        logic k_done;
        logic k_in_mask;
        logic best_inf;
        logic trace_done;
        logic emit_last;
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hkops_ram.sv =====
`default_nettype none
module hkops_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hkops_dp.sv =====
`default_nettype none
module hkops_dp
    import hkops_pkg::*;
#(
    parameter int NODES = 8
) (
    input  wire logic              aclk,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic [2:0]        s_from_node,
    input  wire logic [2:0]        s_to_node,
    input  wire logic [ARC_W-1:0]  s_arc_cost,
    input  wire logic [3:0]        cfg_node_count,
    input  wire logic [2:0]        cfg_start_node,
    output logic      [2:0]        m_tour_node,
    output logic      [2:0]        m_position,
    output logic      [COST_W-1:0] m_path_cost,
    output logic                   m_found,
    output logic                   m_last
);

    localparam int NW     = $clog2(NODES);
    localparam int CW     = NW + 1;
    localparam int MW     = NODES + 1;
    localparam int DAW    = NODES + NW;
    localparam int DDEPTH = 1 << DAW;
    localparam int AAW    = 2 * NW;
    localparam int ADEPTH = 1 << AAW;
    localparam int DW     = COST_W + NW;

    logic [CW-1:0]     n_reg;
    logic [NW-1:0]     depot_reg;
    logic [DAW:0]      clr_reg;
    logic [MW-1:0]     mask_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     k_reg;
    logic [COST_W-1:0] cur_reg;
    logic [COST_W-1:0] min_cost_reg;
    logic [NW-1:0]     min_end_reg;
    logic [NODES-1:0]  tmask_reg;
    logic [NW-1:0]     tcur_reg;
    logic [CW-1:0]     ti_reg;
    logic [NW-1:0]     path_reg [NODES];
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     cnt_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic              found_reg;

    logic [CW-1:0]     n_calc;
    logic [NW-1:0]     depot_calc;
    logic [NW-1:0]     j_idx;
    logic [NW-1:0]     k_idx;
    logic [NODES-1:0]  relax_mask;
    logic [NODES-1:0]  all_mask;
    logic [DAW-1:0]    dp_raddr;
    logic [DAW-1:0]    dp_waddr;
    logic [DW-1:0]     dp_wdata;
    logic [DW-1:0]     dp_rdata;
    logic              dp_we;
    logic              dp_re;
    logic [COST_W-1:0] dp_cost;
    logic [NW-1:0]     dp_pred;
    logic [ARC_W-1:0]  arc_rdata;
    logic              arc_we;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] nd;
    logic              better;

    assign j_idx      = j_reg[NW-1:0];
    assign k_idx      = k_reg[NW-1:0];
    assign relax_mask = mask_reg[NODES-1:0] | (NODES'(1) << k_idx);
    assign all_mask   = NODES'((MW'(1) << n_reg) - MW'(1));
    assign dp_cost    = dp_rdata[DW-1:NW];
    assign dp_pred    = dp_rdata[NW-1:0];

    // Clamp the configured node count and depot.
    always_comb begin
        if (cfg_node_count == '0) begin
            n_calc = CW'(1);
        end else if (32'(cfg_node_count) > NODES) begin
            n_calc = CW'(NODES);
        end else begin
            n_calc = CW'(cfg_node_count);
        end
        if (32'(cfg_start_node) > 32'(n_calc) - 1) begin
            depot_calc = NW'(32'(n_calc) - 1);
        end else begin
            depot_calc = NW'(32'(cfg_start_node));
        end
    end

    // Relaxation: saturating add, unreachable arcs stay infinite.
    always_comb begin
        sum = {1'b0, cur_reg} + (COST_W + 1)'(arc_rdata);
        if (arc_rdata == ARC_NONE || sum[COST_W]) begin
            nd = INF_COST;
        end else begin
            nd = sum[COST_W-1:0];
        end
        better = nd < dp_cost;
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_CUR:   dp_raddr = {mask_reg[NODES-1:0], j_idx};
            RD_RELAX: dp_raddr = {relax_mask, k_idx};
            RD_BEST:  dp_raddr = {all_mask, j_idx};
            RD_TRACE: dp_raddr = {tmask_reg, tcur_reg};
            default:  dp_raddr = '0;
        endcase
        unique case (cmd.wr_sel)
            WR_CLEAR: begin
                dp_waddr = clr_reg[DAW-1:0];
                dp_wdata = {INF_COST, NW'(0)};
                dp_we    = 1'b1;
            end
            WR_SEED: begin
                dp_waddr = {NODES'(1) << depot_reg, depot_reg};
                dp_wdata = '0;
                dp_we    = 1'b1;
            end
            WR_RELAX: begin
                dp_waddr = {relax_mask, k_idx};
                dp_wdata = {nd, j_idx};
                dp_we    = better;
            end
            default: begin
                dp_waddr = '0;
                dp_wdata = '0;
                dp_we    = 1'b0;
            end
        endcase
    end

    assign dp_re  = cmd.rd_sel != RD_NONE;
    assign arc_we = cmd.load_arc && (32'(s_from_node) < NODES) && (32'(s_to_node) < NODES);

    hkops_ram #(
        .WIDTH(DW),
        .DEPTH(DDEPTH)
    ) u_dp_ram (
        .aclk (aclk),
        .we   (dp_we),
        .waddr(dp_waddr),
        .wdata(dp_wdata),
        .re   (dp_re),
        .raddr(dp_raddr),
        .rdata(dp_rdata)
    );

    hkops_ram #(
        .WIDTH(ARC_W),
        .DEPTH(ADEPTH)
    ) u_arc_ram (
        .aclk (aclk),
        .we   (arc_we),
        .waddr({NW'(32'(s_from_node)), NW'(32'(s_to_node))}),
        .wdata(s_arc_cost),
        .re   (cmd.rd_sel == RD_RELAX),
        .raddr({j_idx, k_idx}),
        .rdata(arc_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            n_reg     <= n_calc;
            depot_reg <= depot_calc;
            clr_reg   <= '0;
        end
        if (cmd.clr_step) begin
            clr_reg <= clr_reg + (DAW + 1)'(1);
        end
        if (cmd.mask_reset) begin
            mask_reg <= '0;
        end else if (cmd.mask_inc) begin
            mask_reg <= mask_reg + MW'(1);
        end
        if (cmd.j_reset || cmd.best_init) begin
            j_reg <= '0;
        end else if (cmd.j_inc) begin
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.k_reset) begin
            k_reg <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.latch_cur) begin
            cur_reg <= dp_cost;
        end
        if (cmd.best_init) begin
            min_cost_reg <= INF_COST;
            min_end_reg  <= depot_reg;
        end else if (cmd.best_cmp && dp_cost < min_cost_reg) begin
            min_cost_reg <= dp_cost;
            min_end_reg  <= j_idx;
        end
        if (cmd.trace_init) begin
            tmask_reg <= all_mask;
            tcur_reg  <= min_end_reg;
            ti_reg    <= '0;
        end else if (cmd.trace_step) begin
            path_reg[NW'(n_reg - CW'(1) - ti_reg)] <= tcur_reg;
            tmask_reg <= tmask_reg ^ (NODES'(1) << tcur_reg);
            tcur_reg  <= dp_pred;
            ti_reg    <= ti_reg + CW'(1);
        end
        if (cmd.emit_single || cmd.emit_fail) begin
            path_reg[0]  <= depot_reg;
            cnt_reg      <= CW'(1);
            pos_reg      <= '0;
            out_cost_reg <= cmd.emit_fail ? INF_COST : '0;
            found_reg    <= cmd.emit_single;
        end else if (cmd.emit_ok) begin
            cnt_reg      <= n_reg;
            pos_reg      <= '0;
            out_cost_reg <= min_cost_reg;
            found_reg    <= 1'b1;
        end else if (cmd.pos_inc) begin
            pos_reg <= pos_reg + CW'(1);
        end
    end

    always_comb begin
        status.n_is_one       = n_reg == CW'(1);
        status.clr_done       = clr_reg[DAW];
        status.mask_done      = mask_reg == (MW'(1) << n_reg);
        status.mask_has_depot = mask_reg[depot_reg];
        status.j_done         = j_reg == n_reg;
        status.j_in_mask      = mask_reg[j_idx];
        status.cur_inf        = dp_cost == INF_COST;
        status.k_done         = k_reg == n_reg;
        status.k_in_mask      = mask_reg[k_idx];
        status.best_inf       = min_cost_reg == INF_COST;
        status.trace_done     = ti_reg == n_reg;
        status.emit_last      = pos_reg == cnt_reg - CW'(1);
    end

    assign m_tour_node = 3'(path_reg[pos_reg[NW-1:0]]);
    assign m_position  = 3'(pos_reg);
    assign m_path_cost = out_cost_reg;
    assign m_found     = found_reg;
    assign m_last      = status.emit_last;

endmodule
`default_nettype wire

// ===== hw/rtl/hkops_ctrl.sv =====
`default_nettype none
`include "held_karp_open_path_solver_defines.svh"
module hkops_ctrl
    import hkops_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire logic    s_command,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_SOLVE) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SETUP;
                    end else begin
                        cmd.load_arc = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                if (status.n_is_one) begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_EMIT;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (status.clr_done) begin
                    state_next = ST_SEED;
                end else begin
                    cmd.clr_step = 1'b1;
                    cmd.wr_sel   = WR_CLEAR;
                end
            end
            ST_SEED: begin
                cmd.wr_sel     = WR_SEED;
                cmd.mask_reset = 1'b1;
                state_next     = ST_MASK;
            end
            ST_MASK: begin
                if (status.mask_done) begin
                    cmd.best_init = 1'b1;
                    state_next    = ST_BEST;
                end else if (!status.mask_has_depot) begin
                    cmd.mask_inc = 1'b1;
                end else begin
                    cmd.j_reset = 1'b1;
                    state_next  = ST_JCHK;
                end
            end
            ST_JCHK: begin
                if (status.j_done) begin
                    cmd.mask_inc = 1'b1;
                    state_next   = ST_MASK;
                end else if (!status.j_in_mask) begin
                    cmd.j_inc = 1'b1;
                end else begin
                    cmd.rd_sel = RD_CUR;
                    state_next = ST_JWAIT;
                end
            end
            ST_JWAIT: begin
                cmd.latch_cur = 1'b1;
                if (status.cur_inf) begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_JCHK;
                end else begin
                    cmd.k_reset = 1'b1;
                    state_next  = ST_KCHK;
                end
            end
            ST_KCHK: begin
                if (status.k_done) begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_JCHK;
                end else if (status.k_in_mask) begin
                    cmd.k_inc = 1'b1;
                end else begin
                    cmd.rd_sel = RD_RELAX;
                    state_next = ST_KWAIT;
                end
            end
            ST_KWAIT: begin
                cmd.wr_sel = WR_RELAX;
                cmd.k_inc  = 1'b1;
                state_next = ST_KCHK;
            end
            ST_BEST: begin
                if (status.j_done) begin
                    state_next = ST_BDONE;
                end else begin
                    cmd.rd_sel = RD_BEST;
                    state_next = ST_BWAIT;
                end
            end
            ST_BWAIT: begin
                cmd.best_cmp = 1'b1;
                cmd.j_inc    = 1'b1;
                state_next   = ST_BEST;
            end
            ST_BDONE: begin
                if (status.best_inf) begin
                    cmd.emit_fail = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    cmd.trace_init = 1'b1;
                    state_next     = ST_TRACE;
                end
            end
            ST_TRACE: begin
                if (status.trace_done) begin
                    cmd.emit_ok = 1'b1;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.rd_sel = RD_TRACE;
                    state_next = ST_TWAIT;
                end
            end
            ST_TWAIT: begin
                cmd.trace_step = 1'b1;
                state_next     = ST_TRACE;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.pos_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HKOPS_ASSERT_IMPLY(a_ready_not_emitting, aclk, aresetn, s_ready, !m_valid)
    `HKOPS_ASSERT_NEXT(a_solve_goes_busy, aclk, aresetn, s_valid && s_ready && s_command, !s_ready)
    `HKOPS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)

endmodule
`default_nettype wire

// ===== hw/rtl/held_karp_open_path_solver.sv =====
`default_nettype none
// Held-Karp open-path solver. Load items (command 0) write one 16-bit arc
// cost into the NODES by NODES arc memory and are accepted while idle, so
// arcs can stream back to back. A solve item (command 1) runs the exact
// dynamic program over every subset that contains the depot and then emits
// the cheapest open path, depot first, one result item per node, each
// carrying the total cost, with last set on the final node. A solve first
// sweeps all 2**(NODES + clog2(NODES)) entries of the subset table (2048 at
// eight nodes) to infinite, one entry a cycle. In the relaxation every
// subset visits each candidate end; each end inside the subset fetches its
// cost, and each reachable end then tries every next node outside the
// subset. Then the cheapest end is picked over all nodes and the parents
// are traced back; a full solve is bound by the single read port of the
// subset table.
// The block takes no new item until the last result of a solve is taken.
// With a single node, the depot alone is emitted with cost zero; when no
// finite path exists the depot alone is emitted with cost all ones and found
// clear. An arc cost of 65535 marks an unreachable arc, and path sums
// saturate at all ones. Every arc that a solve reads must have been loaded
// beforehand. The user must write configuration over the APB port only
// while the block is idle; the block itself does not enforce it. The
// node_count register is at byte address 0 and start_node at byte address
// 4; node_count is clamped to 1 through NODES, the depot to that minus one.
module held_karp_open_path_solver
    import hkops_pkg::*;
#(
    parameter int NODES = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input items.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [2:0]        s_from_node,
    input  wire logic [2:0]        s_to_node,
    input  wire logic [ARC_W-1:0]  s_arc_cost,
    // Result items.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [2:0]        m_tour_node,
    output logic      [2:0]        m_position,
    output logic      [COST_W-1:0] m_path_cost,
    output logic                   m_found,
    output logic                   m_last,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic [3:0] node_count_reg;
    logic [2:0] start_node_reg;
    logic       cfg_write;
    cmd_t       cmd;
    status_t    status;

    // The register index is the byte address divided by four.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 4'd8;
            start_node_reg <= 3'd0;
        end else if (cfg_write) begin
            if (32'(paddr[2]) == REG_NODE_COUNT) begin
                node_count_reg <= pwdata[3:0];
            end else begin
                start_node_reg <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (32'(paddr[2]) == REG_START_NODE) begin
            prdata = {29'd0, start_node_reg};
        end else begin
            prdata = {28'd0, node_count_reg};
        end
    end

    // The controller sequences the subset, end and next-node loops; the
    // datapath holds the counters, the arc and subset memories and the
    // result registers.
    hkops_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_command(s_command),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hkops_dp #(
        .NODES(NODES)
    ) u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .status        (status),
        .s_from_node   (s_from_node),
        .s_to_node     (s_to_node),
        .s_arc_cost    (s_arc_cost),
        .cfg_node_count(node_count_reg),
        .cfg_start_node(start_node_reg),
        .m_tour_node   (m_tour_node),
        .m_position    (m_position),
        .m_path_cost   (m_path_cost),
        .m_found       (m_found),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire
